[hw/rtl/flc_pkg.sv]
// Package of shared types and constants for the fully associative LRU cache model.
package flc_pkg;

    localparam int LINE_SIZE_BYTES = 64;
    localparam int NUM_LINES       = 64;
    localparam int ADDRESS_BITS    = 32;

    // Fixed widths of the beat fields.
    localparam int IN_ADDR_W = 32;
    localparam int EVICT_W   = 26;
    localparam int COUNT_W   = 32;

    // Only the low ADDRESS_BITS of the 32-bit address take part; line size is a power of two.
    localparam int ADDR_USED   = (ADDRESS_BITS < IN_ADDR_W) ? ADDRESS_BITS : IN_ADDR_W;
    localparam int OFFSET_BITS = $clog2(LINE_SIZE_BYTES);
    localparam int TAG_W       = ADDR_USED - OFFSET_BITS;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef logic [TAG_W-1:0] t_tag;

    typedef struct packed {
        logic                 command;
        logic [IN_ADDR_W-1:0] byte_address;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic               evicted_valid;
        logic [EVICT_W-1:0] evicted_line;
        logic [COUNT_W-1:0] misses_so_far;
    } t_out_item;

    // Lookup token that walks the cell chain: the line searched for and the line pushed down.
    typedef struct packed {
        logic active;
        t_tag key;
        t_tag carry;
    } t_tok;

    // What a cell reports while the token sits at its input.
    typedef struct packed {
        logic stop;
        logic hit;
    } t_cell_st;

endpackage

[hw/rtl/fully_associative_lru_cache_model_core.sv]
// A clear beat writes its result into the output register when it is accepted.
// An access sends a lookup token down the chain; it stops at the line on a hit or at the first
// free entry on a miss, and a miss on a full cache walks the whole chain and evicts the tail line.
// One item is in flight at a time: the lookup token walks the chain one cell
// per cycle, so the chain length sets the worst case. Reset (synchronous, active low) empties
// every entry, zeroes the miss count and leaves the output channel empty.
module fully_associative_lru_cache_model_core
    import flc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    // Controller state and the registered token fed to the head of the chain.
    logic               r_state, n_state;
    t_tok               r_tok0;
    logic [COUNT_W-1:0] r_miss, n_miss;
    logic               r_ov;
    t_out_item          r_out, n_out;
    logic               load;

    // The chain: tok[i] enters cell i, tok[NUM_LINES] leaves the tail as an evicted line.
    t_tok                 tok [NUM_LINES+1];
    t_cell_st             st  [NUM_LINES];
    logic [NUM_LINES-1:0] stop_vec;
    logic [NUM_LINES-1:0] hit_vec;
    logic [NUM_LINES:0]   act_vec;

    logic accept;
    logic clear;
    logic stop_any;
    logic hit_any;
    logic evict;
    logic done;
    t_tag line_in;

    // The input is taken only in idle with the output register free by this edge, so a
    // finishing lookup always finds room for its result.
    assign o_in_stall = (r_state != ST_IDLE) || (r_ov && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign clear      = accept && (i_in_item.command == CMD_CLEAR);
    assign line_in    = i_in_item.byte_address[ADDR_USED-1:OFFSET_BITS];

    assign tok[0] = r_tok0;

    for (genvar g = 0; g < NUM_LINES; g++) begin : g_cell
        flc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (clear),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .o_st    (st[g])
        );
        assign stop_vec[g] = st[g].stop;
        assign hit_vec[g]  = st[g].hit;
        assign act_vec[g]  = tok[g].active;
    end
    assign act_vec[NUM_LINES] = tok[NUM_LINES].active;

    // Only one cell holds the token at a time, so a plain OR picks out its report.
    assign stop_any = |stop_vec;
    assign hit_any  = |hit_vec;
    assign evict    = tok[NUM_LINES].active;
    assign done     = (r_state == ST_BUSY) && (stop_any || evict);

    always_comb begin
        n_state = r_state;
        n_miss  = r_miss;
        n_out   = r_out;
        load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (clear) begin
                    n_miss = '0;
                    n_out  = '0;
                    load   = 1'b1;
                end else if (accept) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (done) begin
                    // A miss counts one, saturating at the top of the counter.
                    if (!hit_any && (r_miss != {COUNT_W{1'b1}})) begin
                        n_miss = r_miss + COUNT_W'(1);
                    end
                    n_out.hit           = hit_any;
                    n_out.evicted_valid = evict;
                    n_out.evicted_line  = evict ? EVICT_W'(tok[NUM_LINES].carry) : '0;
                    n_out.misses_so_far = (!hit_any && (r_miss != {COUNT_W{1'b1}}))
                                          ? r_miss + COUNT_W'(1) : r_miss;
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tok0.active <= 1'b0;
            r_miss       <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_tok0.active <= accept && (i_in_item.command == CMD_ACCESS);
            r_miss        <= n_miss;
            if (load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // The new line enters the head of the stack as both search key and pushed line.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tok0.key   <= line_in;
            r_tok0.carry <= line_in;
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    // A result is only ever written into a free or draining output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_ov || !i_out_stall))
        else $error("result written over a beat still waiting");

    // At most one lookup token is anywhere in the chain.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(act_vec))
        else $error("more than one token in the cell chain");

    // While idle the chain carries no token.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (act_vec == '0))
        else $error("token in the chain while idle");

    // An accepted access starts a lookup: the controller turns busy and stalls the input.
    a_busy_after_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in_item.command == CMD_ACCESS)) |=> (r_state == ST_BUSY) && o_in_stall)
        else $error("access accepted without starting a lookup");

endmodule

[hw/rtl/flc_cell.sv]
// One entry of the recency-ordered line stack, passing the lookup token to its neighbour.
module flc_cell
    import flc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_clear,
    input  t_tok     i_tok,
    output t_tok     o_tok,
    output t_cell_st o_st
);

    logic r_valid;
    t_tag r_tag;
    t_tok r_tok;
    logic match;

    assign match = r_valid && (r_tag == i_tok.key);

    always_comb begin
        o_st.hit  = i_tok.active && match;
        o_st.stop = i_tok.active && (match || !r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_tok.active <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= 1'b0;
            end else if (i_tok.active) begin
                r_valid <= 1'b1;
            end
            r_tok.active <= i_tok.active && r_valid && !match;
        end
    end

    // The entry takes the line pushed down from above; its old line moves on.
    always_ff @(posedge i_clk) begin
        if (i_tok.active) begin
            r_tag       <= i_tok.carry;
            r_tok.key   <= i_tok.key;
            r_tok.carry <= r_tag;
        end
    end

    assign o_tok = r_tok;

endmodule
